FILE: rtl/lesf_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers of the largest empty square finder
// no dependencies

package lesf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

  // one cell in flight between the input register and the size stage
  typedef struct packed {
    logic             is_obstacle;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             map_end;
  } lesf_cell_t;

  function automatic logic [SIZE_W-1:0] min3(input logic [SIZE_W-1:0] a,
                                             input logic [SIZE_W-1:0] b,
                                             input logic [SIZE_W-1:0] c);
    logic [SIZE_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

FILE: rtl/largest_empty_square_finder.sv
`timescale 1ns / 1ps
// top level of the largest empty square finder
// depends on lesf_pkg, lesf_line_ram, lesf_cell

// Usage
//   cfg port: write map_width (index 0) and map_height (index 1) while the
//   block is idle; 0 is taken as 1 and values above 1024 saturate to 1024.
//   in channel: one beat per map cell in row-major order, carrying the
//   obstacle bit. the block takes one cell per cycle, back to back, while in_stall is low.
//   out channel: one beat per map, after its last cell: the side of the
//   largest empty square and its top-left row and column; ties go to the
//   topmost, then leftmost square. a map with no empty cell gives 0 at 0,0.
// Timing
//   a cell goes through the input register (which also issues the line-store
//   read); the size logic behind it updates the running best and, for the
//   last cell of a map, loads the result register.
//   the result beat comes from the result register, which the last cell loads as it leaves the input register.
//   sustained rate is one cell per cycle unless out_stall holds a result, set by the
//   single read and single write per cycle on the previous-row line store.
// Reset and stall
//   synchronous active-low reset clears the scan counters, the best square
//   and both valid flags and sets both dimensions to 1. the line store is not
//   cleared; the first row of each map discards what it reads from it.
//   while out_stall holds a finished result, cells keep flowing until the
//   last cell of the next map reaches the input register; then in_stall rises.

module largest_empty_square_finder (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [lesf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]        cfg_wdata,
  // cell input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_is_obstacle,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lesf_pkg::SIZE_W-1:0]       out_best_size,
  output logic [lesf_pkg::ROW_W-1:0]        out_top_row,
  output logic [lesf_pkg::COL_W-1:0]        out_left_column
);

  localparam int SIZE_W = lesf_pkg::SIZE_W;
  localparam int CFG_W  = lesf_pkg::CFG_W;
  localparam int COL_W  = lesf_pkg::COL_W;
  localparam int ROW_W  = lesf_pkg::ROW_W;

  // configuration registers
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [CFG_W-1:0] width_eff;
  logic [CFG_W-1:0] height_eff;

  // scan position of the next cell to be accepted
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic [CFG_W-1:0] col_inc;
  logic [CFG_W-1:0] row_inc;
  logic             row_end;
  logic             map_end;

  // input register (stage 1)
  logic                 s1_valid_r;
  lesf_pkg::lesf_cell_t s1_cell_r;
  lesf_pkg::lesf_cell_t s1_cell_nxt;
  logic                 s1_fire;
  logic                 in_accept;

  // size stage state
  logic [SIZE_W-1:0] up_raw;
  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] cell_size;
  logic [SIZE_W-1:0] left_r;
  logic [SIZE_W-1:0] diag_r;
  logic [SIZE_W-1:0] best_size_r;
  logic [ROW_W-1:0]  best_row_r;
  logic [COL_W-1:0]  best_col_r;
  logic [SIZE_W-1:0] best_size_nxt;
  logic [ROW_W-1:0]  best_row_nxt;
  logic [COL_W-1:0]  best_col_nxt;

  // result register
  logic              out_valid_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [SIZE_W-1:0] top_full;
  logic [SIZE_W-1:0] left_full;
  logic              out_free;

  // ---------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(1);
      height_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lesf_pkg::CFG_MAP_WIDTH:  width_r  <= cfg_wdata;
        lesf_pkg::CFG_MAP_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    width_eff = width_r;
    if (width_r == '0) begin
      width_eff = CFG_W'(1);
    end else if (width_r > CFG_W'(lesf_pkg::MAX_WIDTH)) begin
      width_eff = CFG_W'(lesf_pkg::MAX_WIDTH);
    end
    height_eff = height_r;
    if (height_r == '0) begin
      height_eff = CFG_W'(1);
    end else if (height_r > CFG_W'(lesf_pkg::MAX_HEIGHT)) begin
      height_eff = CFG_W'(lesf_pkg::MAX_HEIGHT);
    end
  end

  // ---------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------
  assign out_free  = !out_valid_r || !out_stall;
  // only the last cell of a map needs room in the result register
  assign s1_fire   = s1_valid_r && (!s1_cell_r.map_end || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------
  // scan counters, advanced at accept since they depend only on config
  // ---------------------------------------------------------------
  assign col_inc = CFG_W'(col_r) + CFG_W'(1);
  assign row_inc = CFG_W'(row_r) + CFG_W'(1);
  assign row_end = (col_inc >= width_eff);
  assign map_end = row_end && (row_inc >= height_eff);

  always_comb begin
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = row_r;
    if (map_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_inc[ROW_W-1:0];
    end
  end

  always_comb begin
    s1_cell_nxt.is_obstacle = in_is_obstacle;
    s1_cell_nxt.col         = col_r;
    s1_cell_nxt.row         = row_r;
    s1_cell_nxt.map_end     = map_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cell_r <= s1_cell_nxt;
    end
  end

  // ---------------------------------------------------------------
  // previous-row line store: read issued at accept, written at fire
  // ---------------------------------------------------------------
  lesf_line_ram u_line_ram (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_cell_r.col),
    .wr_data (cell_size),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (up_raw)
  );

  // ---------------------------------------------------------------
  // size stage
  // ---------------------------------------------------------------
  lesf_cell u_cell (
    .cur      (s1_cell_r),
    .up_raw   (up_raw),
    .left_raw (left_r),
    .diag_raw (diag_r),
    .up       (up),
    .size     (cell_size)
  );

  // strictly larger only, so row-major order keeps topmost then leftmost
  always_comb begin
    best_size_nxt = best_size_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    if (cell_size > best_size_r) begin
      best_size_nxt = cell_size;
      best_row_nxt  = s1_cell_r.row;
      best_col_nxt  = s1_cell_r.col;
    end
  end

  // top-left corner from the bottom-right one, wrapped to the field width
  assign top_full  = SIZE_W'(best_row_nxt) - best_size_nxt + SIZE_W'(1);
  assign left_full = SIZE_W'(best_col_nxt) - best_size_nxt + SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        // upper value of this column is the diagonal of the next one
        left_r <= cell_size;
        diag_r <= up;
        if (s1_cell_r.map_end) begin
          best_size_r <= '0;
          best_row_r  <= '0;
          best_col_r  <= '0;
        end else begin
          best_size_r <= best_size_nxt;
          best_row_r  <= best_row_nxt;
          best_col_r  <= best_col_nxt;
        end
      end
      if (s1_fire && s1_cell_r.map_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cell_r.map_end) begin
      if (best_size_nxt == '0) begin
        out_size_r <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
      end else begin
        out_size_r <= best_size_nxt;
        out_row_r  <= top_full[ROW_W-1:0];
        out_col_r  <= left_full[COL_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_size   = out_size_r;
  assign out_top_row     = out_row_r;
  assign out_left_column = out_col_r;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------

  // an empty result always sits at the origin
  a_empty_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_best_size == '0) |-> (out_top_row == '0) && (out_left_column == '0))
    else $error("empty result not at origin");

  // a new result beat only follows a map's last cell leaving the size stage
  a_result_from_map_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_cell_r.map_end))
    else $error("result without end of map");

  // a held cell in the input register keeps its contents
  a_held_cell_stable: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_cell_r))
    else $error("held cell changed");

  // the best square restarts after every map
  a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_cell_r.map_end |=> (best_size_r == '0))
    else $error("best square not cleared at end of map");

endmodule

FILE: rtl/lesf_line_ram.sv
`timescale 1ns / 1ps
// previous-row line store: one write port, one registered read port
// depends on lesf_pkg

module lesf_line_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [lesf_pkg::COL_W-1:0]     wr_addr,
  input  logic [lesf_pkg::SIZE_W-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [lesf_pkg::COL_W-1:0]     rd_addr,
  output logic [lesf_pkg::SIZE_W-1:0]    rd_data
);

  logic [lesf_pkg::SIZE_W-1:0] mem [lesf_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-cycle write to the read address is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: rtl/lesf_cell.sv
`timescale 1ns / 1ps
// square size at one cell: 0 at an obstacle, else 1 + min of neighbors
// depends on lesf_pkg

module lesf_cell (
  input  lesf_pkg::lesf_cell_t           cur,
  input  logic [lesf_pkg::SIZE_W-1:0]    up_raw,
  input  logic [lesf_pkg::SIZE_W-1:0]    left_raw,
  input  logic [lesf_pkg::SIZE_W-1:0]    diag_raw,
  output logic [lesf_pkg::SIZE_W-1:0]    up,
  output logic [lesf_pkg::SIZE_W-1:0]    size
);

  logic [lesf_pkg::SIZE_W-1:0] left;
  logic [lesf_pkg::SIZE_W-1:0] diag;
  logic                        top_edge;
  logic                        left_edge;

  assign top_edge  = (cur.row == '0);
  assign left_edge = (cur.col == '0);

  // neighbors outside the map count as zero
  assign up   = top_edge ? '0 : up_raw;
  assign left = left_edge ? '0 : left_raw;
  assign diag = (top_edge || left_edge) ? '0 : diag_raw;

  assign size = cur.is_obstacle ? '0
              : lesf_pkg::min3(up, left, diag) + lesf_pkg::SIZE_W'(1);

endmodule
